### design/prsl_pkg.sv
// Shared constants, codes and types of the polygon region scanline lookup.
// Used by the front, queue, back and top-level modules; depends on nothing.
package prsl_pkg;

  localparam int MAP_SLOTS = 4;
  localparam int ROWS_PER_MAP = 256;
  localparam int CROSSINGS_PER_ROW = 16;
  localparam int STACK_DEPTH = 8;

  localparam int ROW_TOTAL = MAP_SLOTS * ROWS_PER_MAP;
  localparam int CROSS_TOTAL = ROW_TOTAL * CROSSINGS_PER_ROW;

  localparam int SLOT_W = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
  localparam int ROW_W = $clog2(ROW_TOTAL);
  localparam int CROSS_W = $clog2(CROSS_TOTAL);
  localparam int CNT_W = $clog2(CROSSINGS_PER_ROW + 1);
  localparam int DEP_W = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_QUERY    = 2'd0,
    ACT_WR_CROSS = 2'd1,
    ACT_WR_COUNT = 2'd2,
    ACT_WR_SIDE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_t;

  typedef enum logic [1:0] {
    CMD_RESULT,
    CMD_WR_CROSS,
    CMD_WR_COUNT,
    CMD_WALK
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_COUNT,
    B_WALK
  } back_state_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ROW_W-1:0]   row;
    logic [CNT_W-1:0]   entry;
    logic [15:0]        xpos;
    logic [15:0]        value;
    logic [15:0]        area;
    logic               ovf;
  } cmd_t;

endpackage

### design/prsl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; width and depth come from its parameters.
module prsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/prsl_front.sv
// Front end: accepts input transactions, holds box sides and loaded flags,
// and classifies each transaction into a command for the back end. Uses prsl_pkg.
module prsl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     action,
  input  logic [2:0]     map_id,
  input  logic [16:0]    coord_x,
  input  logic [16:0]    coord_y,
  input  logic [3:0]     entry_index,
  input  logic [15:0]    write_value,
  input  logic [15:0]    write_area,
  input  logic           q_full,
  input  logic           clearing,
  output logic           push,
  output prsl_pkg::cmd_t cmd
);
  import prsl_pkg::*;

  logic [15:0]       box_left   [MAP_SLOTS];
  logic [15:0]       box_right  [MAP_SLOTS];
  logic [15:0]       box_top    [MAP_SLOTS];
  logic [15:0]       box_bottom [MAP_SLOTS];
  logic [MAP_SLOTS-1:0] loaded;

  logic              map_ok;
  logic [SLOT_W-1:0] slot;
  logic [15:0]       x16;
  logic [15:0]       y16;
  logic              neg;
  logic              in_box;
  logic [15:0]       row_off;
  logic              wrow_ok;
  logic              side_wr;

  assign in_ready = !q_full && !clearing;
  assign push = in_valid && in_ready;

  assign map_ok = (map_id != 3'd0) && (int'(map_id) <= MAP_SLOTS);
  assign slot = SLOT_W'(map_id - 3'd1);
  assign x16 = coord_x[15:0];
  assign y16 = coord_y[15:0];
  assign neg = coord_x[16] || coord_y[16];
  assign in_box = (x16 >= box_left[slot]) && (x16 <= box_right[slot]) &&
                  (y16 > box_top[slot]) && (y16 < box_bottom[slot]);
  assign row_off = y16 - box_top[slot];
  assign wrow_ok = !coord_y[16] && (int'(y16) < ROWS_PER_MAP);
  assign side_wr = push && (action_t'(action) == ACT_WR_SIDE) && map_ok &&
                   (entry_index[3:2] == 2'b00);

  always_comb begin
    cmd.kind = CMD_RESULT;
    cmd.row = '0;
    cmd.entry = CNT_W'(entry_index);
    cmd.xpos = x16;
    cmd.value = write_value;
    cmd.area = write_area;
    cmd.ovf = 1'b0;
    case (action_t'(action))
      ACT_QUERY: begin
        if (!neg && map_ok && loaded[slot] && in_box) begin
          if (int'(row_off) >= ROWS_PER_MAP) begin
            cmd.ovf = 1'b1;
          end else begin
            cmd.kind = CMD_WALK;
            cmd.row = ROW_W'(int'(slot) * ROWS_PER_MAP + int'(row_off));
          end
        end
      end
      ACT_WR_CROSS: begin
        if (map_ok && wrow_ok && (int'(entry_index) < CROSSINGS_PER_ROW)) begin
          cmd.kind = CMD_WR_CROSS;
          cmd.row = ROW_W'(int'(slot) * ROWS_PER_MAP + int'(y16));
        end
      end
      ACT_WR_COUNT: begin
        if (map_ok && wrow_ok) begin
          cmd.kind = CMD_WR_COUNT;
          cmd.row = ROW_W'(int'(slot) * ROWS_PER_MAP + int'(y16));
          if (int'(write_value) > CROSSINGS_PER_ROW) begin
            cmd.value = 16'(CROSSINGS_PER_ROW);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (side_wr) begin
      case (side_t'(entry_index[1:0]))
        SIDE_LEFT:   box_left[slot] <= write_value;
        SIDE_RIGHT:  box_right[slot] <= write_value;
        SIDE_TOP:    box_top[slot] <= write_value;
        SIDE_BOTTOM: box_bottom[slot] <= write_value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (side_wr) begin
      loaded[slot] <= 1'b1;
    end
  end

endmodule

### design/prsl_queue.sv
// Short command queue between the front end and the back end.
// Uses prsl_pkg for the command type and queue depth.
module prsl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  prsl_pkg::cmd_t push_cmd,
  input  logic           pop,
  output prsl_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import prsl_pkg::*;

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/prsl_back.sv
// Back end: holds the row count and crossing memories, executes writes, walks
// a row's crossings with the nesting stack, and drives the result register.
// Uses prsl_pkg and prsl_ram.
module prsl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  prsl_pkg::cmd_t head,
  output logic           pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    area_found,
  output logic           hit,
  output logic           overflow
);
  import prsl_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [ROW_W-1:0]   clr_addr;
  logic [15:0]        xq;
  logic [CROSS_W-1:0] base;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [15:0]        former;
  logic [15:0]        stack [STACK_DEPTH];
  logic [DEP_W-1:0]   depth;
  logic               ovf_q;

  logic               out_free;
  logic [CROSS_W-1:0] head_base;
  logic               cnt_we;
  logic [ROW_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [CNT_W-1:0]   cnt_rdata;
  logic               cross_we;
  logic [CROSS_W-1:0] cross_raddr;
  logic [31:0]        cross_rdata;
  logic [15:0]        owner;
  logic [15:0]        top_area;
  logic               load_out;
  logic [15:0]        out_area_next;
  logic               out_ovf_next;
  logic               walk_start;
  logic               step;

  assign clearing = (state == B_CLEAR);
  assign out_free = !out_valid || out_ready;
  assign head_base = CROSS_W'(int'(head.row) * CROSSINGS_PER_ROW);
  assign owner = cross_rdata[31:16];
  assign top_area = (depth != '0) ? stack[SIDX_W'(depth - 1'b1)] : 16'd0;

  prsl_ram #(
    .WIDTH(CNT_W),
    .DEPTH(ROW_TOTAL)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(head.row),
    .rdata(cnt_rdata)
  );

  prsl_ram #(
    .WIDTH(32),
    .DEPTH(CROSS_TOTAL)
  ) u_cross_ram (
    .clk  (clk),
    .we   (cross_we),
    .waddr(head_base + CROSS_W'(head.entry)),
    .wdata({head.area, head.value}),
    .raddr(cross_raddr),
    .rdata(cross_rdata)
  );

  always_comb begin
    state_next = state;
    pop = 1'b0;
    cnt_we = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    cross_we = 1'b0;
    cross_raddr = base;
    load_out = 1'b0;
    out_area_next = 16'd0;
    out_ovf_next = 1'b0;
    walk_start = 1'b0;
    step = 1'b0;
    case (state)
      B_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_addr == ROW_W'(ROW_TOTAL - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          case (head.kind)
            CMD_RESULT: begin
              load_out = 1'b1;
              out_ovf_next = head.ovf;
            end
            CMD_WR_CROSS: begin
              cross_we = 1'b1;
              load_out = 1'b1;
            end
            CMD_WR_COUNT: begin
              cnt_we = 1'b1;
              cnt_waddr = head.row;
              cnt_wdata = head.value[CNT_W-1:0];
              load_out = 1'b1;
            end
            CMD_WALK: begin
              walk_start = 1'b1;
              state_next = B_COUNT;
            end
            default: begin
            end
          endcase
        end
      end
      B_COUNT: begin
        cross_raddr = base;
        state_next = B_WALK;
      end
      B_WALK: begin
        if ((idx < cnt) && (xq > cross_rdata[15:0])) begin
          step = 1'b1;
          cross_raddr = base + CROSS_W'(idx) + 1'b1;
        end else begin
          load_out = 1'b1;
          out_area_next = top_area;
          out_ovf_next = ovf_q;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      idx <= '0;
      cnt <= '0;
      ovf_q <= 1'b0;
    end else if (walk_start) begin
      depth <= '0;
      idx <= '0;
      ovf_q <= 1'b0;
    end else if (state == B_COUNT) begin
      cnt <= cnt_rdata;
    end else if (step) begin
      idx <= idx + 1'b1;
      if (owner != former) begin
        if (int'(depth) < STACK_DEPTH) begin
          depth <= depth + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (depth != '0) begin
        depth <= depth - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_start) begin
      xq <= head.xpos;
      base <= head_base;
      former <= 16'd0;
    end else if (step) begin
      former <= owner;
      if ((owner != former) && (int'(depth) < STACK_DEPTH)) begin
        stack[SIDX_W'(depth)] <= owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      area_found <= out_area_next;
      hit <= (out_area_next != 16'd0);
      overflow <= out_ovf_next;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= STACK_DEPTH)
    else $error("nesting stack depth beyond its size");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == B_WALK) |-> (idx <= cnt))
    else $error("walk index passed the row crossing count");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> (!out_valid && !pop))
    else $error("transaction handled during the clearing pass");

  a_hit_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == (area_found != 16'd0)))
    else $error("hit flag disagrees with area id");
`endif

endmodule

### design/polygon_region_scanline_lookup_top.sv
// Polygon region scanline lookup: after reset the block clears all ROW_TOTAL
// (1024) rows of the row count memory and takes no input transaction
// meanwhile. A write or a rejected query is then handled by the back end
// straight from its idle state; a query that walks a row visits the row's
// crossings up to the first at or past its x (at most CROSSINGS_PER_ROW),
// one crossing per cycle through the crossing memory's single read
// port. A two-entry command queue lets the front end accept transactions while
// a walk is in progress, and a result register holds each answer until taken.
// Uses prsl_pkg, prsl_front, prsl_queue and prsl_back.
module polygon_region_scanline_lookup_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [2:0]  map_id,
  input  logic [16:0] coord_x,
  input  logic [16:0] coord_y,
  input  logic [3:0]  entry_index,
  input  logic [15:0] write_value,
  input  logic [15:0] write_area,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] area_found,
  output logic        hit,
  output logic        overflow
);
  import prsl_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic clearing;

  prsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .map_id     (map_id),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .entry_index(entry_index),
    .write_value(write_value),
    .write_area (write_area),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .cmd        (cmd)
  );

  prsl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(cmd),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  prsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .area_found(area_found),
    .hit       (hit),
    .overflow  (overflow)
  );

endmodule
